// ===== hdl/fvn_pkg.sv =====
// ----------------------------------------------------------------------------
// fvn_pkg: shared types, constants and functions for the fractal noise unit
// Holds the octave stage limits, register indexes, hash constants and the
// smootherstep weight function.
// ----------------------------------------------------------------------------
package fvn_pkg;

   localparam int MAX_OCTAVES_DEF    = 16;
   localparam int WEIGHT_ENTRIES_DEF = 512;
   localparam int WEIGHT_BITS        = 9;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_OCTAVE_COUNT   = 3'd0,
      REG_FIRST_OCTAVE   = 3'd1,
      REG_PERSISTENCE    = 3'd2,
      REG_FREQUENCY_LOG2 = 3'd3,
      REG_NOISE_SEED     = 3'd4,
      REG_CONTRAST_SCALE = 3'd5,
      REG_COLOR_LOW      = 3'd6,
      REG_COLOR_HIGH     = 3'd7
   } csr_index_type;

   localparam logic [31:0] HASH_MUL_A  = 32'd15731;
   localparam logic [31:0] HASH_ADD_A  = 32'd789221;
   localparam logic [31:0] HASH_ADD_B  = 32'd1376312589;
   localparam logic [31:0] HASH_MASK   = 32'h7fffffff;
   localparam logic [31:0] HASH_BASE   = 32'd2048;
   localparam logic [31:0] ROW_MUL     = 32'd31337;
   localparam logic [31:0] SEED_STEP   = 32'hdeadbeef;
   localparam logic [31:0] SEED_MUL    = 32'hb37fa184;
   localparam logic [31:0] SEED_ADD    = 32'd303 * 32'd31337;
   localparam logic [31:0] AMP_START   = 32'd32768;
   localparam logic [31:0] SM_OFFSET   = 32'd32768;
   localparam logic [16:0] SM_MAX      = 17'd65536;

   // floor(1024 * s(i/512)), smootherstep
   function automatic logic [9:0] weight_lookup(input logic [WEIGHT_BITS-1:0] idx);
      logic [63:0] k;
      logic [63:0] poly;
      logic [63:0] prod;
      k    = 64'(idx);
      poly = 64'd2621440 - 64'd7680 * k + 64'd6 * k * k;
      prod = (k * k * k * poly) << 10;
      return prod[54:45];
   endfunction

   // first half of the lattice hash: up to the squared term
   typedef struct packed {
      logic [31:0] n;
      logic [31:0] sq;
   } hash_mid_type;

   function automatic logic [31:0] hash_pre(input logic [31:0] v);
      return v ^ (v << 13);
   endfunction

endpackage

// ===== hdl/fvn_stream_if.sv =====
// ----------------------------------------------------------------------------
// fvn_stream_if: valid/ready channel carrying one payload word
// ----------------------------------------------------------------------------
interface fvn_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/fractal_value_noise_pixel_unit.sv =====
// ----------------------------------------------------------------------------
// fractal_value_noise_pixel_unit: fractal value noise pixel colorizer
// Sums up to MAX_OCTAVES octaves of 2D value noise and blends two colors.
// ----------------------------------------------------------------------------
// One pixel word is accepted and one color word leaves per cycle unless the output
// is stalled. The pipe is made of the seed stage, the unrolled chain of
// seven-stage octave segments and the scale, clamp and blend stages; the whole pipe
// advances together and holds when the output is stalled.
// Octaves above the configured range pass their word through untouched; those below it scale only the amplitude.
module fractal_value_noise_pixel_unit #(
   parameter int MAX_OCTAVES = fvn_pkg::MAX_OCTAVES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   fvn_stream_if.sink                         req,
   fvn_stream_if.source                       rsp,
   input  logic                               csr_write_enable,
   input  logic [fvn_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [fvn_pkg::CSR_DATA_BITS-1:0]  csr_write_data
);

   logic [4:0]  octave_count_ff;
   logic [3:0]  first_octave_ff;
   logic [16:0] persistence_ff;
   logic [3:0]  frequency_log2_ff;
   logic [31:0] noise_seed_ff;
   logic [31:0] contrast_scale_ff;
   logic [23:0] color_low_ff;
   logic [23:0] color_high_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         octave_count_ff   <= 5'd4;
         first_octave_ff   <= '0;
         persistence_ff    <= 17'd32768;
         frequency_log2_ff <= '0;
         noise_seed_ff     <= '0;
         contrast_scale_ff <= 32'd65536;
         color_low_ff      <= '0;
         color_high_ff     <= 24'hffffff;
      end else if (csr_write_enable) begin
         unique case (fvn_pkg::csr_index_type'(csr_index))
            fvn_pkg::REG_OCTAVE_COUNT:   octave_count_ff   <= csr_write_data[4:0];
            fvn_pkg::REG_FIRST_OCTAVE:   first_octave_ff   <= csr_write_data[3:0];
            fvn_pkg::REG_PERSISTENCE:    persistence_ff    <= csr_write_data[16:0];
            fvn_pkg::REG_FREQUENCY_LOG2: frequency_log2_ff <= csr_write_data[3:0];
            fvn_pkg::REG_NOISE_SEED:     noise_seed_ff     <= csr_write_data;
            fvn_pkg::REG_CONTRAST_SCALE: contrast_scale_ff <= csr_write_data;
            fvn_pkg::REG_COLOR_LOW:      color_low_ff      <= csr_write_data[23:0];
            fvn_pkg::REG_COLOR_HIGH:     color_high_ff     <= csr_write_data[23:0];
            default: ;
         endcase
      end
   end

   // effective octave range, static between config writes
   logic [4:0]  count_w;
   logic [4:0]  start_w;
   always_comb begin
      count_w = (octave_count_ff > 5'(MAX_OCTAVES)) ? 5'(MAX_OCTAVES) : octave_count_ff;
      start_w = ({1'b0, first_octave_ff} >= count_w) ? 5'd0 : {1'b0, first_octave_ff};
   end

   // front stage: seed hash
   logic        en;
   logic        out_vld_ff;
   logic        f_vld_ff;
   logic [31:0] f_x_ff, f_y_ff, f_seed_ff;

   assign en        = !out_vld_ff || rsp.ready;
   assign req.ready = en;

   always_ff @(posedge clock) begin
      if (reset) f_vld_ff <= 1'b0;
      else if (en) f_vld_ff <= req.valid;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f_x_ff    <= req.payload[63:32];
         f_y_ff    <= req.payload[31:0];
         f_seed_ff <= (noise_seed_ff + 32'd1) * fvn_pkg::SEED_MUL + fvn_pkg::SEED_ADD;
      end
   end

   // octave chain; amplitude of skipped octaves scales in place
   logic        c_vld  [MAX_OCTAVES+1];
   logic [31:0] c_x    [MAX_OCTAVES+1];
   logic [31:0] c_y    [MAX_OCTAVES+1];
   logic [31:0] c_seed [MAX_OCTAVES+1];
   logic [31:0] c_amp  [MAX_OCTAVES+1];
   logic [31:0] c_sum  [MAX_OCTAVES+1];

   assign c_vld[0]  = f_vld_ff;
   assign c_x[0]    = f_x_ff;
   assign c_y[0]    = f_y_ff;
   assign c_seed[0] = f_seed_ff;
   assign c_amp[0]  = fvn_pkg::AMP_START;
   assign c_sum[0]  = '0;

   for (genvar o = 0; o < MAX_OCTAVES; o++) begin : g_oct
      logic [5:0]  e;
      logic [31:0] mask;
      logic        act;
      logic        skip;
      logic [31:0] amp_sel;
      logic [48:0] amp_prod;
      always_comb begin
         e    = 6'(frequency_log2_ff) + 6'(o);
         mask = (e >= 6'd32) ? 32'hffffffff : ((32'd1 << e[4:0]) - 32'd1);
         act  = (5'(o) >= start_w) && (5'(o) < count_w);
         skip = 5'(o) < start_w;
         amp_prod = 49'(c_amp[o]) * 49'(persistence_ff);
         amp_sel  = skip ? 32'($signed(amp_prod[31:0]) >>> 16) : c_amp[o];
      end
      fvn_octave u_oct (
         .clock, .reset, .en,
         .vld_in(c_vld[o]), .x_in(c_x[o]), .y_in(c_y[o]), .seed_in(c_seed[o]),
         .amp_in(amp_sel), .sum_in(c_sum[o]), .mask_in(mask), .act_in(act),
         .persistence(persistence_ff),
         .vld_out(c_vld[o+1]), .x_out(c_x[o+1]), .y_out(c_y[o+1]),
         .seed_out(c_seed[o+1]), .amp_out(c_amp[o+1]), .sum_out(c_sum[o+1])
      );
   end

   // back: scale, clamp, blend
   logic        s_vld_ff, m_vld_ff;
   logic [63:0] prod_ff;
   logic [16:0] sm_ff;
   logic [31:0] smv;
   logic [47:0] out_ff;
   logic [47:0] blend_w;

   always_comb begin
      smv = prod_ff[47:16] + fvn_pkg::SM_OFFSET;
      for (int ch = 0; ch < 3; ch++) begin
         logic [31:0] base, diff, mp;
         base = {16'd0, color_low_ff[ch*8 +: 8], 8'd0};
         diff = {16'd0, color_high_ff[ch*8 +: 8], 8'd0} - base;
         mp   = {15'd0, sm_ff} * diff;
         blend_w[ch*16 +: 16] = 16'(base + (mp >> 16));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_vld_ff <= 1'b0; m_vld_ff <= 1'b0; out_vld_ff <= 1'b0;
      end else if (en) begin
         s_vld_ff <= c_vld[MAX_OCTAVES];
         m_vld_ff <= s_vld_ff;
         out_vld_ff <= m_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= $signed(c_sum[MAX_OCTAVES]) * $signed(contrast_scale_ff);
         if (smv[31]) sm_ff <= '0;
         else if (smv > 32'(fvn_pkg::SM_MAX)) sm_ff <= fvn_pkg::SM_MAX;
         else sm_ff <= smv[16:0];
         out_ff <= blend_w;
      end
   end

   assign rsp.valid   = out_vld_ff;
   assign rsp.payload = out_ff;

`ifndef SYNTHESIS
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.payload))
      else $error("result word changed while stalled");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp.valid |-> req.ready)
      else $error("input stalled with empty output");
   a_front: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> f_vld_ff)
      else $error("accepted word not captured");
`endif

endmodule

// ===== hdl/fvn_octave.sv =====
// ----------------------------------------------------------------------------
// fvn_octave: one noise octave as a pipeline segment
// Hashes four lattice corners, mixes them with smootherstep weights and, when
// act_in is set, adds amplitude times noise into the running sum. It holds LAT
// (seven) stages, advancing on en.
// ----------------------------------------------------------------------------
module fvn_octave (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        vld_in,
   input  logic [31:0] x_in,
   input  logic [31:0] y_in,
   input  logic [31:0] seed_in,
   input  logic [31:0] amp_in,
   input  logic [31:0] sum_in,
   input  logic [31:0] mask_in,
   input  logic        act_in,
   input  logic [16:0] persistence,
   output logic        vld_out,
   output logic [31:0] x_out,
   output logic [31:0] y_out,
   output logic [31:0] seed_out,
   output logic [31:0] amp_out,
   output logic [31:0] sum_out
);

   localparam int LAT    = 7;
   localparam int W_BITS = fvn_pkg::WEIGHT_BITS;

   // stage-carried context
   logic [LAT-1:0] vld_ff;
   logic [31:0]    x_ff    [LAT];
   logic [31:0]    y_ff    [LAT];
   logic [31:0]    seed_ff [LAT];
   logic [31:0]    amp_ff  [LAT];
   logic [31:0]    sum_ff  [LAT];
   logic           act_ff  [LAT-1];

   // smootherstep weight ROM, registered read per axis
   logic [9:0] weight_rom [fvn_pkg::WEIGHT_ENTRIES_DEF];

   for (genvar i = 0; i < fvn_pkg::WEIGHT_ENTRIES_DEF; i++) begin : g_rom
      assign weight_rom[i] = fvn_pkg::weight_lookup(W_BITS'(i));
   end

   // stage 0: corner hash inputs, weights, row products
   logic [31:0] hin_ff [4];
   logic [9:0]  wx_ff, wy_ff;
   logic [31:0] hin_in [4];
   logic [31:0] ix, iy, jx, jy, iym, jym;

   always_comb begin
      ix  = {10'd0, x_in[31:10]};
      iy  = {10'd0, y_in[31:10]};
      jx  = (ix + 32'd1) & mask_in;
      jy  = (iy + 32'd1) & mask_in;
      iym = iy * fvn_pkg::ROW_MUL;
      jym = jy * fvn_pkg::ROW_MUL;
      hin_in[0] = ix + seed_in + iym;
      hin_in[1] = jx + seed_in + iym;
      hin_in[2] = ix + seed_in + jym;
      hin_in[3] = jx + seed_in + jym;
   end

   // stage 1: n and n*n
   logic [31:0] hn_ff [4];
   logic [31:0] hsq_ff [4];
   // stage 2: t
   logic [31:0] hn2_ff [4];
   logic [31:0] ht_ff [4];
   // stage 3: hash value
   logic [31:0] hv_ff [4];
   logic [31:0] hmix [4];
   // stage 4: row mixes
   logic [31:0] top_ff, bot_ff;
   // stage 5: column mix and noise
   logic [31:0] noise_ff;
   // stage 6: product and next amplitude
   logic [31:0] mix_w;
   logic [31:0] top_in, bot_in;
   logic [9:0]  wx1_ff, wx2_ff, wx3_ff, wy1_ff, wy2_ff, wy3_ff, wy4_ff;
   logic [48:0] amp_prod;

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         hmix[c] = ((hn2_ff[c] * ht_ff[c]) + fvn_pkg::HASH_ADD_B) & fvn_pkg::HASH_MASK;
      end
   end

   always_comb begin
      top_in = (hv_ff[0] << 10) + (hv_ff[1] - hv_ff[0]) * {22'd0, wx3_ff};
      bot_in = (hv_ff[2] << 10) + (hv_ff[3] - hv_ff[2]) * {22'd0, wx3_ff};
      mix_w  = (top_ff << 10) + (bot_ff - top_ff) * {22'd0, wy4_ff};
      amp_prod = 49'(amp_ff[5]) * 49'(persistence);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], vld_in};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0] <= x_in; y_ff[0] <= y_in; seed_ff[0] <= seed_in;
         amp_ff[0] <= amp_in; sum_ff[0] <= sum_in; act_ff[0] <= act_in;
         for (int s = 1; s < LAT-1; s++) begin
            x_ff[s] <= x_ff[s-1]; y_ff[s] <= y_ff[s-1];
            seed_ff[s] <= seed_ff[s-1]; amp_ff[s] <= amp_ff[s-1];
            sum_ff[s] <= sum_ff[s-1]; act_ff[s] <= act_ff[s-1];
         end
         for (int c = 0; c < 4; c++) begin
            hin_ff[c] <= hin_in[c];
            hn_ff[c]  <= fvn_pkg::hash_pre(hin_ff[c]);
            hsq_ff[c] <= fvn_pkg::hash_pre(hin_ff[c]) * fvn_pkg::hash_pre(hin_ff[c]);
            hn2_ff[c] <= hn_ff[c];
            ht_ff[c]  <= hsq_ff[c] * fvn_pkg::HASH_MUL_A + fvn_pkg::HASH_ADD_A;
            hv_ff[c]  <= fvn_pkg::HASH_BASE - (hmix[c] >> 19);
         end
         wx_ff  <= weight_rom[x_in[9:1]];
         wy_ff  <= weight_rom[y_in[9:1]];
         wx1_ff <= wx_ff;  wx2_ff <= wx1_ff; wx3_ff <= wx2_ff;
         wy1_ff <= wy_ff;  wy2_ff <= wy1_ff; wy3_ff <= wy2_ff; wy4_ff <= wy3_ff;
         top_ff <= top_in;
         bot_ff <= bot_in;
         noise_ff <= 32'($signed(mix_w) >>> 20);
         // stage 6 output
         if (act_ff[LAT-2]) begin
            sum_ff[LAT-1]  <= sum_ff[LAT-2] + amp_ff[LAT-2] * noise_ff;
            x_ff[LAT-1]    <= x_ff[LAT-2] << 1;
            y_ff[LAT-1]    <= y_ff[LAT-2] << 1;
            seed_ff[LAT-1] <= seed_ff[LAT-2] + fvn_pkg::SEED_STEP;
            amp_ff[LAT-1]  <= 32'($signed(amp_prod[31:0]) >>> 16);
         end else begin
            sum_ff[LAT-1]  <= sum_ff[LAT-2];
            x_ff[LAT-1]    <= x_ff[LAT-2];
            y_ff[LAT-1]    <= y_ff[LAT-2];
            seed_ff[LAT-1] <= seed_ff[LAT-2];
            amp_ff[LAT-1]  <= amp_ff[LAT-2];
         end
      end
   end

   assign vld_out  = vld_ff[LAT-1];
   assign x_out    = x_ff[LAT-1];
   assign y_out    = y_ff[LAT-1];
   assign seed_out = seed_ff[LAT-1];
   assign amp_out  = amp_ff[LAT-1];
   assign sum_out  = sum_ff[LAT-1];

endmodule

// ===== sim/fractal_value_noise_pixel_unit_test.sv =====
// ----------------------------------------------------------------------------
// fractal_value_noise_pixel_unit_test: self-checking bench for the noise unit
// Drives pixel coordinate words through several register settings, shades
// each one with a local fixed-point noise predictor or a known color, and compares
// every color word field by field, with random idling and back pressure on both channels.
// ----------------------------------------------------------------------------
module fractal_value_noise_pixel_unit_test;

   typedef struct packed {
      logic [31:0] x_coord;
      logic [31:0] y_coord;
   } pixel_word_type;

   typedef struct packed {
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
   } color_word_type;

   typedef struct {
      logic [31:0]    x;
      logic [31:0]    y;
      bit             known;
      color_word_type color;
   } pixel_row_type;

   localparam int PIPE_CYCLES = 1 + 7 * 16 + 3;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [fvn_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [fvn_pkg::CSR_DATA_BITS-1:0]  csr_write_data;

   fvn_stream_if #(.payload_type(pixel_word_type)) req_if ();
   fvn_stream_if #(.payload_type(color_word_type)) rsp_if ();

   fractal_value_noise_pixel_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_if),
      .rsp              (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // local register copy
   logic [4:0]  octave_cnt;
   logic [3:0]  first_oct;
   logic [16:0] persist;
   logic [3:0]  freq_log2;
   logic [31:0] seed_reg;
   logic [31:0] contrast;
   logic [23:0] col_low;
   logic [23:0] col_high;

   logic [9:0]     smooth_w [512];
   color_word_type expected_colors [$];
   pixel_row_type  rows [$];
   int             mismatches;
   bit             sender_idle_on;
   bit             sink_idle_on;
   bit             long_hold_req;

   // handshake state sampled mid-cycle, consumed at the next rising edge
   logic           req_ready_s;
   logic           rsp_fire_s;
   color_word_type rsp_word_s;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("TB_ERROR");
      $finish;
   end

   always @(negedge clock) begin
      req_ready_s = req_if.ready;
      rsp_fire_s  = rsp_if.valid && rsp_if.ready;
      rsp_word_s  = rsp_if.payload;
   end

   function automatic logic [31:0] lattice_value(input logic [31:0] v);
      logic [31:0] n;
      logic [31:0] t;
      n = v ^ (v << 13);
      t = n * n * 32'd15731 + 32'd789221;
      n = n * t + 32'd1376312589;
      n = n & 32'h7fffffff;
      return 32'd2048 - (n >> 19);
   endfunction

   function automatic logic [31:0] octave_noise(input logic [31:0] x, input logic [31:0] y,
                                                 input logic [31:0] mask,
                                                 input logic [31:0] seed);
      logic [31:0] ix, iy, jx, jy, wx, wy, a, b, top, bot, mix;
      ix  = x >> 10;
      iy  = y >> 10;
      jx  = (ix + 32'd1) & mask;   // only the far corner wraps
      jy  = (iy + 32'd1) & mask;
      wx  = 32'(smooth_w[x[9:1]]);
      wy  = 32'(smooth_w[y[9:1]]);
      ix  = ix + seed;
      jx  = jx + seed;
      iy  = iy * 32'd31337;
      jy  = jy * 32'd31337;
      a   = lattice_value(ix + iy);
      b   = lattice_value(jx + iy);
      top = (a << 10) + (b - a) * wx;
      a   = lattice_value(ix + jy);
      b   = lattice_value(jx + jy);
      bot = (a << 10) + (b - a) * wx;
      mix = (top << 10) + (bot - top) * wy;
      return $signed(mix) >>> 20;
   endfunction

   function automatic logic [15:0] blend(input logic [7:0] lo, input logic [7:0] hi,
                                         input logic [31:0] sm);
      logic [31:0] base, diff, part;
      base = 32'(lo) << 8;
      diff = (32'(hi) << 8) - base;
      part = sm * diff;
      return 16'(base + (part >> 16));
   endfunction

   function automatic color_word_type shade_pixel(input pixel_word_type p);
      logic [31:0]    cnt, start, xv, yv, seed, amp, sum, e, mask, tmp, sm;
      longint         prod;
      int             smv;
      color_word_type c;
      cnt   = (octave_cnt > 5'd16) ? 32'd16 : 32'(octave_cnt);
      start = (32'(first_oct) >= cnt) ? 32'd0 : 32'(first_oct);
      xv    = p.x_coord;
      yv    = p.y_coord;
      seed  = (seed_reg + 32'd1) * fvn_pkg::SEED_MUL + fvn_pkg::SEED_ADD;
      amp   = 32'd32768;
      sum   = 32'd0;
      for (int o = 0; o < start; o++) begin
         tmp = amp * 32'(persist);
         amp = $signed(tmp) >>> 16;
      end
      for (int o = start; o < cnt; o++) begin
         e    = 32'(freq_log2) + 32'(o);
         mask = (e >= 32) ? 32'hffffffff : ((32'd1 << e) - 32'd1);
         sum  = sum + amp * octave_noise(xv, yv, mask, seed);
         xv   = xv << 1;
         yv   = yv << 1;
         seed = seed + fvn_pkg::SEED_STEP;
         tmp  = amp * 32'(persist);
         amp  = $signed(tmp) >>> 16;
      end
      prod = longint'($signed(sum)) * longint'($signed(contrast));
      smv  = $signed(prod[47:16] + 32'd32768);
      if (smv < 0)
         smv = 0;
      if (smv > 65536)
         smv = 65536;
      sm      = 32'(smv);
      c.red   = blend(col_low[23:16], col_high[23:16], sm);
      c.green = blend(col_low[15:8], col_high[15:8], sm);
      c.blue  = blend(col_low[7:0], col_high[7:0], sm);
      return c;
   endfunction

   task automatic note_mismatch(input string what, input logic [15:0] exp_v,
                                input logic [15:0] act_v);
      if (mismatches < 10)
         $display("mismatch %s: expected %h got %h", what, exp_v, act_v);
      mismatches++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_fire_s) begin
         if (expected_colors.size() == 0) begin
            if (mismatches < 10)
               $display("unexpected color word %h", rsp_word_s);
            mismatches++;
         end else begin
            color_word_type e;
            e = expected_colors.pop_front();
            if (e.red !== rsp_word_s.red)
               note_mismatch("red", e.red, rsp_word_s.red);
            if (e.green !== rsp_word_s.green)
               note_mismatch("green", e.green, rsp_word_s.green);
            if (e.blue !== rsp_word_s.blue)
               note_mismatch("blue", e.blue, rsp_word_s.blue);
         end
      end
   end

   // result side: random stalls, plus one long hold when asked
   initial begin
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      while (reset)
         @(posedge clock);
      forever begin
         if (long_hold_req) begin
            rsp_if.ready <= 1'b0;
            repeat (400) @(posedge clock);
            long_hold_req = 1'b0;
         end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   task automatic write_reg(input fvn_pkg::csr_index_type idx, input logic [31:0] val);
      unique case (idx)
         fvn_pkg::REG_OCTAVE_COUNT:   octave_cnt = val[4:0];
         fvn_pkg::REG_FIRST_OCTAVE:   first_oct  = val[3:0];
         fvn_pkg::REG_PERSISTENCE:    persist    = val[16:0];
         fvn_pkg::REG_FREQUENCY_LOG2: freq_log2  = val[3:0];
         fvn_pkg::REG_NOISE_SEED:     seed_reg   = val;
         fvn_pkg::REG_CONTRAST_SCALE: contrast   = val;
         fvn_pkg::REG_COLOR_LOW:      col_low    = val[23:0];
         fvn_pkg::REG_COLOR_HIGH:     col_high   = val[23:0];
      endcase
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= val;
      @(posedge clock);
   endtask

   task automatic write_all(input logic [31:0] cnt, input logic [31:0] first,
                            input logic [31:0] pers, input logic [31:0] flog,
                            input logic [31:0] seed, input logic [31:0] cs,
                            input logic [31:0] lo, input logic [31:0] hi);
      write_reg(fvn_pkg::REG_OCTAVE_COUNT, cnt);
      write_reg(fvn_pkg::REG_FIRST_OCTAVE, first);
      write_reg(fvn_pkg::REG_PERSISTENCE, pers);
      write_reg(fvn_pkg::REG_FREQUENCY_LOG2, flog);
      write_reg(fvn_pkg::REG_NOISE_SEED, seed);
      write_reg(fvn_pkg::REG_CONTRAST_SCALE, cs);
      write_reg(fvn_pkg::REG_COLOR_LOW, lo);
      write_reg(fvn_pkg::REG_COLOR_HIGH, hi);
      csr_write_enable <= 1'b0;
   endtask

   task automatic drain;
      while (expected_colors.size() != 0)
         @(posedge clock);
      repeat (PIPE_CYCLES + 10) @(posedge clock);
   endtask

   task automatic send_pixel(input logic [31:0] x, input logic [31:0] y, input bit known,
                             input color_word_type known_color);
      pixel_word_type p;
      p.x_coord = x;
      p.y_coord = y;
      if (sender_idle_on && $urandom_range(0, 7) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= p;
      do
         @(posedge clock);
      while (!req_ready_s);
      expected_colors.push_back(known ? known_color : shade_pixel(p));
   endtask

   function automatic logic [31:0] rand_coord;
      case ($urandom_range(0, 3))
         0:       return $urandom_range(0, 8191);
         1:       return {$urandom_range(0, 3) == 0 ? 32'hffffffff : $urandom()};
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [31:0] pick(input logic [31:0] lo, input logic [31:0] hi);
      case ($urandom_range(0, 5))
         0:       return lo;
         1:       return hi;
         default: return $urandom_range(lo, hi);
      endcase
   endfunction

   initial begin
      color_word_type mid;
      color_word_type none;
      logic [31:0]    cs;
      for (int i = 0; i < 512; i++) begin
         longint unsigned k, poly, prod;
         k    = i;
         poly = 64'd2621440 - 64'd7680 * k + 64'd6 * k * k;
         prod = (k * k * k * poly) << 10;
         smooth_w[i] = prod[54:45];
      end
      octave_cnt = 5'd4;
      first_oct  = 4'd0;
      persist    = 17'd32768;
      freq_log2  = 4'd0;
      seed_reg   = 32'd0;
      contrast   = 32'd65536;
      col_low    = 24'h000000;
      col_high   = 24'hffffff;
      mismatches     = 0;
      sender_idle_on = 1'b1;
      sink_idle_on   = 1'b1;
      long_hold_req  = 1'b0;
      none = '0;
      mid  = '{red: 16'h7f80, green: 16'h7f80, blue: 16'h7f80};

      reset            <= 1'b1;
      req_if.valid     <= 1'b0;
      req_if.payload   <= '0;
      csr_write_enable <= 1'b0;
      csr_index        <= '0;
      csr_write_data   <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings first, then zero octaves which pins the blend at midpoint
      rows.push_back('{32'h0, 32'h0, 1'b0, none});
      rows.push_back('{32'hffffffff, 32'hffffffff, 1'b0, none});
      rows.push_back('{32'h000003ff, 32'h00000400, 1'b0, none});
      rows.push_back('{32'haaaaaaaa, 32'h55555555, 1'b0, none});
      foreach (rows[i])
         send_pixel(rows[i].x, rows[i].y, rows[i].known, rows[i].color);
      rows.delete();
      req_if.valid <= 1'b0;
      drain();

      write_all(0, 0, 32768, 0, 0, 65536, 24'h000000, 24'hffffff);
      rows.push_back('{32'h0, 32'h0, 1'b1, mid});
      rows.push_back('{32'hffffffff, 32'hffffffff, 1'b1, mid});
      rows.push_back('{32'h12345678, 32'h0, 1'b1, mid});
      foreach (rows[i])
         send_pixel(rows[i].x, rows[i].y, rows[i].known, rows[i].color);
      rows.delete();
      req_if.valid <= 1'b0;
      drain();

      // count saturates past the stage limit; first octave beyond count; big seed
      write_all(31, 15, 65536, 15, 32'hffffffff, 32'h7fffffff, 24'hffffff, 24'h000000);
      rows.push_back('{32'h0, 32'hffffffff, 1'b0, none});
      rows.push_back('{32'hffffffff, 32'h0, 1'b0, none});
      rows.push_back('{32'h000001ff, 32'h000003fe, 1'b0, none});
      rows.push_back('{32'h80000000, 32'h7fffffff, 1'b0, none});
      foreach (rows[i])
         send_pixel(rows[i].x, rows[i].y, rows[i].known, rows[i].color);
      req_if.valid <= 1'b0;
      drain();
      write_all(3, 9, 131071, 14, 32'h0, 32'h80000000, 24'h123456, 24'hfedcba);
      foreach (rows[i])
         send_pixel(rows[i].x, rows[i].y, rows[i].known, rows[i].color);
      req_if.valid <= 1'b0;
      drain();
      write_all(16, 15, 0, 0, 32'h5a5a5a5a, 32'hffffffff, 24'h00ff00, 24'hff00ff);
      foreach (rows[i])
         send_pixel(rows[i].x, rows[i].y, rows[i].known, rows[i].color);
      req_if.valid <= 1'b0;
      drain();

      for (int ph = 0; ph < 12; ph++) begin
         case ($urandom_range(0, 3))
            0:       cs = $urandom();
            1:       cs = pick(0, 262144);
            2:       cs = -pick(0, 262144);
            default: cs = pick(32'h7fff0000, 32'h7fffffff) ^ {1'($urandom_range(0, 1)), 31'h0};
         endcase
         write_all(($urandom_range(0, 5) == 0) ? pick(17, 31) : pick(0, 16), pick(0, 15),
                   ($urandom_range(0, 5) == 0) ? pick(65537, 131071) : pick(0, 65536),
                   pick(0, 15), $urandom(), cs, $urandom_range(0, 24'hffffff),
                   $urandom_range(0, 24'hffffff));
         if (ph == 11) begin
            sender_idle_on = 1'b0;
            sink_idle_on   = 1'b0;
         end
         for (int n = 0; n < 120; n++) begin
            if (ph == 2 && n == 10)
               long_hold_req = 1'b1;
            if (ph == 4 && n == 60) begin
               req_if.valid <= 1'b0;
               while (expected_colors.size() != 0)
                  @(posedge clock);
            end
            send_pixel(rand_coord(), rand_coord(), 1'b0, none);
         end
         req_if.valid <= 1'b0;
         drain();
      end

      if (mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/fvn_pkg.sv
hdl/fvn_stream_if.sv
hdl/fvn_octave.sv
hdl/fractal_value_noise_pixel_unit.sv
sim/fractal_value_noise_pixel_unit_test.sv
